// ===== hw/rtl/bwtd_pkg.sv =====
// ----------------------------------------------------------------------------
// bwtd_pkg
// Shared types and constants for the inverse BWT block decoder.
// ----------------------------------------------------------------------------
package bwtd_pkg;

  localparam int NUM_SYMBOLS      = 'h100;
  localparam int SYM_W            = 8;
  localparam int PIDX_W           = 12;
  localparam int BLOCK_SIZE_DEF   = 4096;

  typedef enum logic [2:0] {
    ST_ACCEPTED  = 3'd0,
    ST_DATA      = 3'd1,
    ST_BAD_INDEX = 3'd2,
    ST_FULL      = 3'd3,
    ST_NONE      = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    E_IDLE,
    E_LD_CNT,
    E_PFX_RD,
    E_PFX_WR,
    E_PL_RD,
    E_PL_SLOT,
    E_PL_WR,
    E_FT_LINK,
    E_FT_BYTE
  } eng_state_t;

  // classified request handed from front to engine
  typedef struct packed {
    logic              is_fetch;
    logic [SYM_W-1:0]  sym;
    logic [PIDX_W-1:0] pidx;
    logic              last;
  } op_t;

  typedef struct packed {
    logic             valid;
    logic [SYM_W-1:0] data;
    logic             last;
    status_t          status;
  } res_t;

endpackage

// ===== hw/rtl/bwt_inverse_block_decoder_top.sv =====
// ----------------------------------------------------------------------------
// bwt_inverse_block_decoder_top
// Inverse BWT block decoder: loads a transformed block, builds the link
// table, then returns the original bytes one request at a time.
// ----------------------------------------------------------------------------
//  channel | handshake    | payload
//  --------+--------------+---------------------------------------------------
//  input   | push / full  | in_req_type, in_symbol, in_primary_index,
//          |              | in_block_end
//  result  | empty / pop  | out_byte, out_last, out_status
//
// A load stores its byte, then bumps its count; a fetch reads the link, then
// the byte; an empty fetch answers at once. The closing load adds an offset
// pass over the 256 counters, then places each byte (one count-memory port).
// Reset is synchronous; no clearing pass, count entries carry valid bits.
// A 2-deep request queue and a result register let either side stall.
module bwt_inverse_block_decoder_top #(
  parameter int BLOCK_SIZE = bwtd_pkg::BLOCK_SIZE_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  output logic                        full,
  input  logic                        in_req_type,
  input  logic [bwtd_pkg::SYM_W-1:0]  in_symbol,
  input  logic [bwtd_pkg::PIDX_W-1:0] in_primary_index,
  input  logic                        in_block_end,
  output logic                        empty,
  input  logic                        pop,
  output logic [bwtd_pkg::SYM_W-1:0]  out_byte,
  output logic                        out_last,
  output logic [2:0]                  out_status
);
  import bwtd_pkg::*;

  logic             op_valid, op_pop;
  op_t              op;
  res_t             res;
  logic             out_valid_r;
  logic [SYM_W-1:0] out_data_r;
  logic             out_last_r;
  status_t          out_status_r;

  bwtd_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .req_type      (in_req_type),
    .symbol        (in_symbol),
    .primary_index (in_primary_index),
    .block_end     (in_block_end),
    .op_valid      (op_valid),
    .op            (op),
    .op_pop        (op_pop)
  );

  bwtd_engine #(.BLOCK_SIZE(BLOCK_SIZE)) u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .op_valid (op_valid),
    .op       (op),
    .op_pop   (op_pop),
    .out_free (!out_valid_r),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid) begin
      out_valid_r <= 1'b1;
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
    if (res.valid) begin
      out_data_r   <= res.data;
      out_last_r   <= res.last;
      out_status_r <= res.status;
    end
  end

  assign empty      = !out_valid_r;
  assign out_byte   = out_data_r;
  assign out_last   = out_last_r;
  assign out_status = out_status_r;

`ifndef ASSERT_OFF
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> !out_valid_r)
    else $error("result written over a waiting result");

  a_last_is_data: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_last) |-> (out_status_r == ST_DATA))
    else $error("last flag on a non-data result");

  a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_status_r != ST_DATA) |-> (out_byte == '0))
    else $error("non-data result carries a byte");
`endif

endmodule

// ===== hw/rtl/bwtd_front.sv =====
// ----------------------------------------------------------------------------
// bwtd_front
// Accepts requests, classifies them and queues them for the engine.
// ----------------------------------------------------------------------------
module bwtd_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  output logic                       full,
  input  logic                       req_type,
  input  logic [bwtd_pkg::SYM_W-1:0]  symbol,
  input  logic [bwtd_pkg::PIDX_W-1:0] primary_index,
  input  logic                       block_end,
  output logic                       op_valid,
  output bwtd_pkg::op_t              op,
  input  logic                       op_pop
);
  import bwtd_pkg::*;

  op_t        q_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] cnt_r;
  op_t        in_op;
  logic       do_push, do_pop;

  assign full     = (cnt_r == 2'd2);
  assign op_valid = (cnt_r != 2'd0);
  assign op       = q_r[rptr_r];
  assign do_push  = push && !full;
  assign do_pop   = op_pop && op_valid;

  always_comb begin
    in_op.is_fetch = req_type;
    in_op.sym      = symbol;
    in_op.pidx     = primary_index;
    in_op.last     = block_end && !req_type;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (do_push) begin
        q_r[wptr_r] <= in_op;
        wptr_r      <= ~wptr_r;
      end
      if (do_pop) rptr_r <= ~rptr_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

// ===== hw/rtl/bwtd_engine.sv =====
// ----------------------------------------------------------------------------
// bwtd_engine
// Executes loads, link building and fetches against the block memories.
// ----------------------------------------------------------------------------
module bwtd_engine #(
  parameter int BLOCK_SIZE = bwtd_pkg::BLOCK_SIZE_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          op_valid,
  input  bwtd_pkg::op_t op,
  output logic          op_pop,
  input  logic          out_free,
  output bwtd_pkg::res_t res
);
  import bwtd_pkg::*;

  localparam int IW = $clog2(BLOCK_SIZE);
  localparam int LW = $clog2(BLOCK_SIZE + 1);
  localparam int CW = (LW > PIDX_W) ? LW : PIDX_W;

  eng_state_t state_r, state_nxt;
  logic [LW-1:0]          len_r, len_nxt, emit_r, emit_nxt, base_r, base_nxt, eff_len;
  logic [IW-1:0]          walk_r, walk_nxt, i_r, i_nxt;
  logic                   ready_r, ready_nxt;
  logic [NUM_SYMBOLS-1:0] cvld_r, cvld_nxt;
  logic [SYM_W-1:0]       s_r, s_nxt, sym_r, sym_nxt;
  logic [PIDX_W-1:0]      pidx_r, pidx_nxt;
  logic                   last_r, last_nxt;

  // memories
  logic [SYM_W-1:0] st_mem [BLOCK_SIZE];
  logic [IW-1:0]    lk_mem [BLOCK_SIZE];
  logic [LW-1:0]    cnt_mem [NUM_SYMBOLS];
  logic [SYM_W-1:0] st_q, st_wd;
  logic [IW-1:0]    lk_q, lk_wd, st_wa, st_ra, lk_wa, lk_ra;
  logic [LW-1:0]    cnt_q, cnt_wd, cnt_val;
  logic [SYM_W-1:0] cnt_wa, cnt_ra;
  logic             st_we, st_re, lk_we, lk_re, cnt_we, cnt_re;

  always_ff @(posedge clk) begin
    if (st_we) st_mem[st_wa] <= st_wd;
    if (st_re) st_q <= st_mem[st_ra];
  end

  always_ff @(posedge clk) begin
    if (lk_we) lk_mem[lk_wa] <= lk_wd;
    if (lk_re) lk_q <= lk_mem[lk_ra];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
    if (cnt_re) cnt_q <= cnt_mem[cnt_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= E_IDLE;
      len_r   <= '0;
      emit_r  <= '0;
      walk_r  <= '0;
      ready_r <= 1'b0;
      cvld_r  <= '0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      emit_r  <= emit_nxt;
      walk_r  <= walk_nxt;
      ready_r <= ready_nxt;
      cvld_r  <= cvld_nxt;
    end
    base_r <= base_nxt;
    i_r    <= i_nxt;
    s_r    <= s_nxt;
    sym_r  <= sym_nxt;
    pidx_r <= pidx_nxt;
    last_r <= last_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    len_nxt   = len_r;
    emit_nxt  = emit_r;
    base_nxt  = base_r;
    walk_nxt  = walk_r;
    i_nxt     = i_r;
    ready_nxt = ready_r;
    cvld_nxt  = cvld_r;
    s_nxt     = s_r;
    sym_nxt   = sym_r;
    pidx_nxt  = pidx_r;
    last_nxt  = last_r;
    eff_len   = len_r;
    op_pop    = 1'b0;
    res       = '{valid: 1'b0, data: '0, last: 1'b0, status: ST_ACCEPTED};
    st_we  = 1'b0; st_wa  = eff_len[IW-1:0]; st_wd  = op.sym;
    st_re  = 1'b0; st_ra  = i_r;
    lk_we  = 1'b0; lk_wa  = cnt_q[IW-1:0];   lk_wd  = i_r;
    lk_re  = 1'b0; lk_ra  = walk_r;
    cnt_we = 1'b0; cnt_wa = sym_r;           cnt_wd = '0;
    cnt_re = 1'b0; cnt_ra = sym_r;
    cnt_val = cvld_r[sym_r] ? cnt_q : '0;

    unique case (state_r)
      E_IDLE: begin
        if (op_valid && out_free) begin
          op_pop   = 1'b1;
          sym_nxt  = op.sym;
          pidx_nxt = op.pidx;
          last_nxt = op.last;
          if (op.is_fetch) begin
            if (!ready_r) begin
              res.valid  = 1'b1;
              res.status = ST_NONE;
            end else begin
              lk_re     = 1'b1;
              state_nxt = E_FT_LINK;
            end
          end else begin
            // a load drops any decode still pending
            if (ready_r) begin
              eff_len   = '0;
              len_nxt   = '0;
              walk_nxt  = '0;
              emit_nxt  = '0;
              ready_nxt = 1'b0;
              cvld_nxt  = '0;
            end
            if (eff_len >= LW'(BLOCK_SIZE)) begin
              res.valid  = 1'b1;
              res.status = ST_FULL;
              if (op.last) begin
                len_nxt  = '0;
                walk_nxt = '0;
                emit_nxt = '0;
                cvld_nxt = '0;
              end
            end else begin
              st_we     = 1'b1;
              st_wa     = eff_len[IW-1:0];
              len_nxt   = eff_len + LW'(1);
              cnt_re    = 1'b1;
              cnt_ra    = op.sym;
              state_nxt = E_LD_CNT;
            end
          end
        end
      end
      E_LD_CNT: begin
        cnt_we           = 1'b1;
        cnt_wa           = sym_r;
        cnt_wd           = cnt_val + LW'(1);
        cvld_nxt[sym_r]  = 1'b1;
        state_nxt        = E_IDLE;
        if (!last_r) begin
          res.valid  = 1'b1;
          res.status = ST_ACCEPTED;
        end else if (CW'(pidx_r) >= CW'(len_r)) begin
          res.valid  = 1'b1;
          res.status = ST_BAD_INDEX;
          len_nxt    = '0;
          walk_nxt   = '0;
          emit_nxt   = '0;
          cvld_nxt   = '0;
        end else begin
          s_nxt     = '0;
          base_nxt  = '0;
          state_nxt = E_PFX_RD;
        end
      end
      E_PFX_RD: begin
        cnt_re    = 1'b1;
        cnt_ra    = s_r;
        state_nxt = E_PFX_WR;
      end
      E_PFX_WR: begin
        // turn count into start offset in place
        cnt_we        = 1'b1;
        cnt_wa        = s_r;
        cnt_wd        = base_r;
        cvld_nxt[s_r] = 1'b1;
        base_nxt      = base_r + (cvld_r[s_r] ? cnt_q : '0);
        s_nxt         = s_r + SYM_W'(1);
        if (s_r == {SYM_W{1'b1}}) begin
          i_nxt     = '0;
          state_nxt = E_PL_RD;
        end else begin
          state_nxt = E_PFX_RD;
        end
      end
      E_PL_RD: begin
        st_re     = 1'b1;
        st_ra     = i_r;
        state_nxt = E_PL_SLOT;
      end
      E_PL_SLOT: begin
        cnt_re    = 1'b1;
        cnt_ra    = st_q;
        state_nxt = E_PL_WR;
      end
      E_PL_WR: begin
        lk_we  = 1'b1;
        lk_wa  = cnt_q[IW-1:0];
        lk_wd  = i_r;
        cnt_we = 1'b1;
        cnt_wa = st_q;
        cnt_wd = cnt_q + LW'(1);
        if (LW'(i_r) + LW'(1) == len_r) begin
          walk_nxt   = IW'(pidx_r);
          emit_nxt   = '0;
          ready_nxt  = 1'b1;
          res.valid  = 1'b1;
          res.status = ST_ACCEPTED;
          state_nxt  = E_IDLE;
        end else begin
          i_nxt     = i_r + IW'(1);
          state_nxt = E_PL_RD;
        end
      end
      E_FT_LINK: begin
        st_re     = 1'b1;
        st_ra     = lk_q;
        walk_nxt  = lk_q;
        state_nxt = E_FT_BYTE;
      end
      E_FT_BYTE: begin
        res.valid  = 1'b1;
        res.status = ST_DATA;
        res.data   = st_q;
        emit_nxt   = emit_r + LW'(1);
        state_nxt  = E_IDLE;
        if (emit_r + LW'(1) >= len_r) begin
          res.last  = 1'b1;
          len_nxt   = '0;
          walk_nxt  = '0;
          emit_nxt  = '0;
          ready_nxt = 1'b0;
          cvld_nxt  = '0;
        end
      end
      default: state_nxt = E_IDLE;
    endcase
  end

endmodule
